[sv/i2cms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and slot decode shared by the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef logic [2:0]  op_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] delay_t;
    typedef logic [5:0]  slot_t;

    // Command codes carried in op; codes above CMD_READ act as tick only
    localparam op_t CMD_IDLE  = 3'd0;
    localparam op_t CMD_START = 3'd1;
    localparam op_t CMD_STOP  = 3'd2;
    localparam op_t CMD_WRITE = 3'd3;
    localparam op_t CMD_READ  = 3'd4;

    localparam delay_t DELAY_RESET = 16'd1;

    // Slot boundaries of the longer sequences
    localparam slot_t WR_BITS_END = 6'd40;
    localparam slot_t RD_FINISH   = 6'd36;

    // Pin action performed at the end of a delay slot
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_SDA_LOW,
        ACT_SDA_HIGH,
        ACT_SCL_LOW,
        ACT_SCL_HIGH,
        ACT_SDA_BIT,
        ACT_RELEASE,
        ACT_DRIVE,
        ACT_SAMPLE_ACK,
        ACT_SAMPLE_BIT,
        ACT_READ_FINISH
    } act_t;

    typedef struct packed {
        act_t act;
        logic last;
    } slot_dec_t;

    // One result item
    typedef struct packed {
        logic  scl_out;
        logic  sda_out;
        logic  sda_drive;
        logic  busy_res;
        logic  done_res;
        logic  nack;
        byte_t read_data;
        logic  rejected;
    } result_t;

    // Slot number modulo 5 for slots below 64: quotient by multiply-shift
    function automatic logic [2:0] slot_mod5(input slot_t slot);
        logic [9:0] prod;
        logic [3:0] quo;
        logic [5:0] rem;
        prod = {4'd0, slot} * 10'd13;
        quo  = prod[9:6];
        rem  = slot - {quo, 2'b00} - {2'b00, quo};
        return rem[2:0];
    endfunction

    // Action and end-of-command flag for slot of a running command
    function automatic slot_dec_t slot_decode(input op_t cmd, input slot_t slot);
        slot_dec_t  dec;
        logic [2:0] ph5;
        slot_t      rd_off;
        ph5    = slot_mod5(slot);
        rd_off = slot - 6'd1;
        dec.act  = ACT_NONE;
        dec.last = 1'b0;
        case (cmd)
            CMD_START:
            begin
                dec.last = (slot >= 6'd4);
                case (slot)
                    6'd1:    dec.act = ACT_SDA_LOW;
                    6'd3:    dec.act = ACT_SCL_LOW;
                    default: dec.act = ACT_NONE;
                endcase
            end
            CMD_STOP:
            begin
                dec.last = (slot >= 6'd3);
                case (slot)
                    6'd0:    dec.act = ACT_SCL_HIGH;
                    6'd1:    dec.act = ACT_SDA_HIGH;
                    default: dec.act = ACT_NONE;
                endcase
            end
            CMD_WRITE:
            begin
                if (slot < WR_BITS_END)
                begin
                    case (ph5)
                        3'd0:    dec.act = ACT_SDA_BIT;
                        3'd1:    dec.act = ACT_SCL_HIGH;
                        3'd2:    dec.act = ACT_SCL_LOW;
                        3'd3:    dec.act = ACT_SDA_LOW;
                        default: dec.act = ACT_NONE;
                    endcase
                end
                else
                begin
                    dec.last = (slot >= 6'd45);
                    case (slot)
                        6'd40:   dec.act = ACT_RELEASE;
                        6'd41:   dec.act = ACT_SCL_HIGH;
                        6'd42:   dec.act = ACT_SAMPLE_ACK;
                        6'd43:   dec.act = ACT_SCL_LOW;
                        6'd44:   dec.act = ACT_DRIVE;
                        default: dec.act = ACT_NONE;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (slot == 6'd0)
                    dec.act = ACT_RELEASE;
                else if (slot == RD_FINISH)
                    dec.act = ACT_READ_FINISH;
                else if (slot < RD_FINISH)
                begin
                    case (rd_off[1:0])
                        2'd0:    dec.act = ACT_SCL_HIGH;
                        2'd1:    dec.act = ACT_SAMPLE_BIT;
                        2'd2:    dec.act = ACT_SCL_LOW;
                        default: dec.act = ACT_NONE;
                    endcase
                end
                else
                    dec.last = 1'b1;
            end
            default:
            begin
                dec.last = 1'b1;
            end
        endcase
        return dec;
    endfunction

endpackage : i2cms_pkg
`default_nettype wire

[sv/i2cms_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels of the sequencer: tick items, result items, config.
// ----------------------------------------------------------------------------

// Tick item channel
interface i2cms_cmd_if;
    logic             valid;
    logic             ready;
    i2cms_pkg::op_t   op;
    i2cms_pkg::byte_t data_byte;
    logic             sda_in;

    modport source (output valid, output op, output data_byte, output sda_in,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input sda_in,
                    output ready);
endinterface : i2cms_cmd_if

// Result item channel
interface i2cms_res_if;
    logic             valid;
    logic             ready;
    logic             scl_out;
    logic             sda_out;
    logic             sda_drive;
    logic             busy_res;
    logic             done_res;
    logic             nack;
    i2cms_pkg::byte_t read_data;
    logic             rejected;

    modport source (output valid, output scl_out, output sda_out, output sda_drive,
                    output busy_res, output done_res, output nack, output read_data,
                    output rejected, input ready);
    modport sink   (input valid, input scl_out, input sda_out, input sda_drive,
                    input busy_res, input done_res, input nack, input read_data,
                    input rejected, output ready);
endinterface : i2cms_res_if

// Configuration write channel: delay_ticks
interface i2cms_cfg_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::delay_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : i2cms_cfg_if
`default_nettype wire

[sv/i2c_master_bit_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master pin sequencer: start, stop, write byte and read byte commands.
// ----------------------------------------------------------------------------
// Each tick item advances the bus sequencer by one tick and may start a
// command; the item yields one result item showing the pins and status after
// that tick. The block takes one item per clock cycle: the whole state update
// is one registered pass through the slot decoder and the tick counter, and
// the result register is reloaded whenever it is empty or being taken, so a
// new item is accepted in the same cycle a result leaves; the result shows
// valid in the next cycle. Each delay slot lasts delay_ticks ticks (zero
// counts as one); a start takes 5 slots, a stop 4, a write 46 and a
// read 38. A command arriving while one runs is ignored and flagged.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core
(
    input  wire            clk,
    input  wire            rst_n,
    i2cms_cmd_if.sink      cmd,
    i2cms_res_if.source    res,
    i2cms_cfg_if.sink      cfg
);
    import i2cms_pkg::*;

    // Sequencer state
    delay_t    delay_reg;
    logic      scl_reg;
    logic      sda_reg;
    logic      sda_en_reg;
    op_t       cmd_reg;
    slot_t     slot_reg;
    logic [8:0] shifter_reg;
    delay_t    tick_reg;
    logic      ack_reg;
    byte_t     last_read_reg;

    logic      out_valid_reg;
    result_t   res_reg;

    // Next values
    logic      scl_next;
    logic      sda_next;
    logic      sda_en_next;
    op_t       cmd_next;
    slot_t     slot_next;
    logic [8:0] shifter_next;
    delay_t    tick_next;
    logic      ack_next;
    byte_t     last_read_next;
    result_t   res_next;

    logic      in_fire;
    logic      is_cmd;
    logic      rej;
    logic      done;
    delay_t    limit;
    logic [16:0] tick_sum;
    slot_dec_t dec;

    assign cfg.ready = 1'b1;
    assign cmd.ready = !out_valid_reg || res.ready;
    assign in_fire   = cmd.valid && cmd.ready;

    assign limit  = (delay_reg == '0) ? DELAY_RESET : delay_reg;
    assign is_cmd = (cmd.op != CMD_IDLE) && (cmd.op <= CMD_READ);

    // Delay register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg.valid)
            delay_reg <= cfg.data;
    end

    // One tick of the sequencer
    always_comb
    begin
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        sda_en_next    = sda_en_reg;
        cmd_next       = cmd_reg;
        slot_next      = slot_reg;
        shifter_next   = shifter_reg;
        tick_next      = tick_reg;
        ack_next       = ack_reg;
        last_read_next = last_read_reg;
        rej            = 1'b0;
        done           = 1'b0;
        dec            = '{act: ACT_NONE, last: 1'b0};
        tick_sum       = '0;

        // command launch or rejection
        if (cmd_reg != CMD_IDLE)
            rej = is_cmd;
        else if (is_cmd)
        begin
            cmd_next     = cmd.op;
            slot_next    = '0;
            tick_next    = '0;
            shifter_next = (cmd.op == CMD_WRITE) ? {1'b0, cmd.data_byte} : 9'd0;
        end

        // tick count and end-of-slot action
        if (cmd_next != CMD_IDLE)
        begin
            tick_sum = {1'b0, tick_next} + 17'd1;
            if (tick_sum >= {1'b0, limit})
            begin
                dec       = slot_decode(cmd_next, slot_next);
                tick_next = '0;
                case (dec.act)
                    ACT_SDA_LOW:   sda_next = 1'b0;
                    ACT_SDA_HIGH:  sda_next = 1'b1;
                    ACT_SCL_LOW:   scl_next = 1'b0;
                    ACT_SCL_HIGH:  scl_next = 1'b1;
                    ACT_SDA_BIT:
                    begin
                        sda_next     = shifter_next[7];
                        shifter_next = {shifter_next[7:0], 1'b0};
                    end
                    ACT_RELEASE:    sda_en_next = 1'b0;
                    ACT_DRIVE:      sda_en_next = 1'b1;
                    ACT_SAMPLE_ACK: ack_next = cmd.sda_in;
                    ACT_SAMPLE_BIT: shifter_next = {shifter_next[7:0], cmd.sda_in};
                    ACT_READ_FINISH:
                    begin
                        sda_en_next    = 1'b1;
                        last_read_next = shifter_next[8:1];
                        ack_next       = shifter_next[0];
                    end
                    default: ;
                endcase
                if (dec.last)
                begin
                    cmd_next  = CMD_IDLE;
                    slot_next = '0;
                    done      = 1'b1;
                end
                else
                    slot_next = slot_next + 6'd1;
            end
            else
                tick_next = tick_sum[15:0];
        end

        res_next.scl_out   = scl_next;
        res_next.sda_out   = sda_next;
        res_next.sda_drive = sda_en_next;
        res_next.busy_res  = (cmd_next != CMD_IDLE);
        res_next.done_res  = done;
        res_next.nack      = ack_next;
        res_next.read_data = last_read_next;
        res_next.rejected  = rej;
    end

    // State update on each accepted tick item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            sda_en_reg    <= 1'b1;
            cmd_reg       <= CMD_IDLE;
            slot_reg      <= '0;
            shifter_reg   <= '0;
            tick_reg      <= '0;
            ack_reg       <= 1'b0;
            last_read_reg <= '0;
        end
        else if (in_fire)
        begin
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            sda_en_reg    <= sda_en_next;
            cmd_reg       <= cmd_next;
            slot_reg      <= slot_next;
            shifter_reg   <= shifter_next;
            tick_reg      <= tick_next;
            ack_reg       <= ack_next;
            last_read_reg <= last_read_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.scl_out   = res_reg.scl_out;
    assign res.sda_out   = res_reg.sda_out;
    assign res.sda_drive = res_reg.sda_drive;
    assign res.busy_res  = res_reg.busy_res;
    assign res.done_res  = res_reg.done_res;
    assign res.nack      = res_reg.nack;
    assign res.read_data = res_reg.read_data;
    assign res.rejected  = res_reg.rejected;

`ifndef NO_ASSERTIONS
    // A command offered while busy shows up as rejected in the next result
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd_reg != CMD_IDLE) && is_cmd) |=> res_reg.rejected)
        else $error("busy command not flagged as rejected");

    // A finished command leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    // The tick counter never reaches the slot length while running
    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg != CMD_IDLE) |-> (tick_reg < limit))
        else $error("tick counter overran the delay slot");

    // Slot index stays inside the write and read slot lists (read ends one past finish), zero while idle
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd_reg == CMD_WRITE) |-> (slot_reg <= 6'd45)) and
        ((cmd_reg == CMD_READ) |-> (slot_reg <= RD_FINISH + 6'd1)) and
        ((cmd_reg == CMD_IDLE) |-> (slot_reg == 6'd0)))
        else $error("slot index out of range");

    // No stall unless a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> cmd.ready)
        else $error("input stalled with empty result register");
`endif

endmodule : i2c_master_bit_sequencer_core
`default_nettype wire

[test/i2c_master_bit_sequencer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_checker
// Watches the tick, pin and config channels of the I2C bit sequencer, runs
// its own model of the bus sequencer on every accepted tick item and
// compares each pin item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_checker
(
    input  wire     clk,
    input  wire     rst_n,
    i2cms_cmd_if    tick,
    i2cms_res_if    pins,
    i2cms_cfg_if    cfg,
    output int      mismatch_count,
    output int      pins_due
);
    import i2cms_pkg::*;

    // Predicted sequencer state
    delay_t      bus_delay;
    logic        m_scl;
    logic        m_sda;
    logic        m_drive;
    op_t         m_cmd;
    slot_t       m_slot;
    logic [3:0]  m_bits;
    logic [8:0]  m_shift;
    logic [15:0] m_ticks;
    logic        m_ack;
    byte_t       m_rdata;

    result_t     pin_states_due[$];
    int          fails;
    int          pin_items_seen;

    // Pin action at the end of slot s of command c; fin marks the final slot
    function automatic act_t action_at_slot(op_t c, slot_t s, output logic fin);
        int unsigned n;
        act_t        a;
        n   = 32'(s);
        a   = ACT_NONE;
        fin = 1'b0;
        case (c)
            CMD_START:
            begin
                fin = (n >= 4);
                if (n == 1)
                    a = ACT_SDA_LOW;
                else if (n == 3)
                    a = ACT_SCL_LOW;
            end
            CMD_STOP:
            begin
                fin = (n >= 3);
                if (n == 0)
                    a = ACT_SCL_HIGH;
                else if (n == 1)
                    a = ACT_SDA_HIGH;
            end
            CMD_WRITE:
            begin
                if (n < WR_BITS_END)
                begin
                    case (n % 5)
                        0:       a = ACT_SDA_BIT;
                        1:       a = ACT_SCL_HIGH;
                        2:       a = ACT_SCL_LOW;
                        3:       a = ACT_SDA_LOW;
                        default: a = ACT_NONE;
                    endcase
                end
                else
                begin
                    fin = (n >= WR_BITS_END + 5);
                    case (n - WR_BITS_END)
                        0:       a = ACT_RELEASE;
                        1:       a = ACT_SCL_HIGH;
                        2:       a = ACT_SAMPLE_ACK;
                        3:       a = ACT_SCL_LOW;
                        4:       a = ACT_DRIVE;
                        default: a = ACT_NONE;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (n == 0)
                    a = ACT_RELEASE;
                else if (n == RD_FINISH)
                    a = ACT_READ_FINISH;
                else if (n < RD_FINISH)
                begin
                    case ((n - 1) % 4)
                        0:       a = ACT_SCL_HIGH;
                        1:       a = ACT_SAMPLE_BIT;
                        2:       a = ACT_SCL_LOW;
                        default: a = ACT_NONE;
                    endcase
                end
                else
                    fin = 1'b1;
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase
        return a;
    endfunction

    // One bus tick: start or reject a command, count the slot, act at its end
    function automatic result_t advance_bus_tick(op_t op, byte_t d, logic sda);
        result_t r;
        logic    is_cmd;
        logic    rej;
        logic    done;
        logic    fin;
        delay_t  lim;
        act_t    a;
        is_cmd = (op >= CMD_START) && (op <= CMD_READ);
        rej    = 1'b0;
        done   = 1'b0;
        lim    = (bus_delay == 16'd0) ? 16'd1 : bus_delay;

        if (m_cmd != CMD_IDLE)
        begin
            if (is_cmd)
                rej = 1'b1;
        end
        else if (is_cmd)
        begin
            m_cmd   = op;
            m_slot  = '0;
            m_ticks = '0;
            m_bits  = '0;
            m_shift = (op == CMD_WRITE) ? {1'b0, d} : 9'd0;
        end

        if (m_cmd != CMD_IDLE)
        begin
            m_ticks = m_ticks + 16'd1;
            if (m_ticks >= lim)
            begin
                a = action_at_slot(m_cmd, m_slot, fin);
                case (a)
                    ACT_SDA_LOW:  m_sda   = 1'b0;
                    ACT_SDA_HIGH: m_sda   = 1'b1;
                    ACT_SCL_LOW:  m_scl   = 1'b0;
                    ACT_SCL_HIGH: m_scl   = 1'b1;
                    ACT_RELEASE:  m_drive = 1'b0;
                    ACT_DRIVE:    m_drive = 1'b1;
                    ACT_SAMPLE_ACK: m_ack = sda;
                    ACT_SDA_BIT:
                    begin
                        m_sda   = m_shift[7];
                        m_shift = {m_shift[7:0], 1'b0};
                        m_bits  = m_bits + 4'd1;
                    end
                    ACT_SAMPLE_BIT:
                    begin
                        m_shift = {m_shift[7:0], sda};
                        if (m_bits < 4'd9)
                            m_bits = m_bits + 4'd1;
                    end
                    ACT_READ_FINISH:
                    begin
                        m_drive = 1'b1;
                        m_rdata = m_shift[8:1];
                        m_ack   = m_shift[0];
                    end
                    default: ;
                endcase
                m_ticks = '0;
                if (fin)
                begin
                    m_cmd  = CMD_IDLE;
                    m_slot = '0;
                    done   = 1'b1;
                end
                else
                    m_slot = m_slot + 6'd1;
            end
        end

        r.scl_out   = m_scl;
        r.sda_out   = m_sda;
        r.sda_drive = m_drive;
        r.busy_res  = (m_cmd != CMD_IDLE);
        r.done_res  = done;
        r.nack      = m_ack;
        r.read_data = m_rdata;
        r.rejected  = rej;
        return r;
    endfunction

    // Names of the fields that differ, empty when all match
    function automatic string differing_fields(result_t e, result_t g);
        string s;
        s = "";
        if (e.scl_out   !== g.scl_out)   s = {s, " scl_out"};
        if (e.sda_out   !== g.sda_out)   s = {s, " sda_out"};
        if (e.sda_drive !== g.sda_drive) s = {s, " sda_drive"};
        if (e.busy_res  !== g.busy_res)  s = {s, " busy_res"};
        if (e.done_res  !== g.done_res)  s = {s, " done_res"};
        if (e.nack      !== g.nack)      s = {s, " nack"};
        if (e.read_data !== g.read_data) s = {s, " read_data"};
        if (e.rejected  !== g.rejected)  s = {s, " rejected"};
        return s;
    endfunction

    // Channel monitor: config first, then pin items, then new tick items
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        string   diffs;
        if (!rst_n)
        begin
            bus_delay      = DELAY_RESET;
            m_scl          = 1'b1;
            m_sda          = 1'b1;
            m_drive        = 1'b1;
            m_cmd          = CMD_IDLE;
            m_slot         = '0;
            m_bits         = '0;
            m_shift        = '0;
            m_ticks        = '0;
            m_ack          = 1'b0;
            m_rdata        = '0;
            fails          = 0;
            pin_items_seen = 0;
            pin_states_due.delete();
            mismatch_count <= 0;
            pins_due       <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                bus_delay = cfg.data;

            if (pins.valid && pins.ready)
            begin
                got.scl_out   = pins.scl_out;
                got.sda_out   = pins.sda_out;
                got.sda_drive = pins.sda_drive;
                got.busy_res  = pins.busy_res;
                got.done_res  = pins.done_res;
                got.nack      = pins.nack;
                got.read_data = pins.read_data;
                got.rejected  = pins.rejected;
                if (pin_states_due.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: pin item %0d arrived with nothing predicted",
                                 $realtime, pin_items_seen);
                    fails++;
                end
                else
                begin
                    want  = pin_states_due.pop_front();
                    diffs = differing_fields(want, got);
                    if (diffs != "")
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: pin item %0d mismatch in%s", $realtime,
                                     pin_items_seen, diffs);
                            $display("  exp scl=%b sda=%b drv=%b busy=%b done=%b nack=%b rd=%02h rej=%b",
                                     want.scl_out, want.sda_out, want.sda_drive,
                                     want.busy_res, want.done_res, want.nack,
                                     want.read_data, want.rejected);
                            $display("  got scl=%b sda=%b drv=%b busy=%b done=%b nack=%b rd=%02h rej=%b",
                                     got.scl_out, got.sda_out, got.sda_drive,
                                     got.busy_res, got.done_res, got.nack,
                                     got.read_data, got.rejected);
                        end
                        fails++;
                    end
                end
                pin_items_seen++;
            end

            if (tick.valid && tick.ready)
                pin_states_due.push_back(advance_bus_tick(tick.op, tick.data_byte,
                                                          tick.sda_in));

            pins_due       <= pin_states_due.size();
            mismatch_count <= fails;
        end
    end

endmodule : i2c_master_bit_sequencer_checker

[test/i2c_master_bit_sequencer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core_test
// Drives bus ticks and commands into the I2C bit sequencer under several
// delay settings and idling patterns; a checker beside the block predicts
// every pin item and the top gives the verdict.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core_test;
    import i2cms_pkg::*;

    // Unassigned op codes, handled as plain ticks
    localparam op_t OP_RSVD_A = 3'd5;
    localparam op_t OP_RSVD_B = 3'd6;
    localparam op_t OP_RSVD_C = 3'd7;

    // SDA level source for tick runs
    localparam int SDA_ZERO = 0;
    localparam int SDA_ONE  = 1;
    localparam int SDA_RAND = 2;

    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    i2cms_cmd_if tick_ch ();
    i2cms_res_if pin_ch ();
    i2cms_cfg_if cfg_ch ();

    int   mismatch_count;
    int   pins_due;

    int   tx_idle_pct = 14;
    int   rx_idle_pct = 70;
    int   hold_req    = 0;
    int   hold_seen;
    int   hold_left;
    logic bus_busy;
    int   items_sent  = 0;
    int   slot_len    = 1;

    i2c_master_bit_sequencer_core i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tick_ch),
        .res   (pin_ch),
        .cfg   (cfg_ch)
    );

    i2c_master_bit_sequencer_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick_ch),
        .pins           (pin_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .pins_due       (pins_due)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Pin item receiver: random stalls, long hold-off on request
    initial
    begin
        pin_ch.ready <= 1'b0;
        bus_busy     <= 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (pin_ch.valid && pin_ch.ready)
                bus_busy <= pin_ch.busy_res;
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pin_ch.ready <= 1'b0;
            end
            else
                pin_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic int slots_in(op_t op);
        case (op)
            CMD_START: return 5;
            CMD_STOP:  return 4;
            CMD_WRITE: return 46;
            CMD_READ:  return 38;
            default:   return 1;
        endcase
    endfunction

    function automatic logic sda_level(int mode);
        if (mode == SDA_ZERO)
            return 1'b0;
        if (mode == SDA_ONE)
            return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    // Offer one tick item, with random idle cycles ahead of it
    task automatic send_item(op_t op, byte_t d, logic sda);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid     <= 1'b1;
        tick_ch.op        <= op;
        tick_ch.data_byte <= d;
        tick_ch.sda_in    <= sda;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        items_sent++;
    endtask

    // Plain ticks; a few become stray commands that land while busy or idle
    task automatic tick_run(int n, int sda_mode, int noise_pct);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_item(op_t'($urandom_range(1, 7)), byte_t'($urandom),
                          sda_level(sda_mode));
            else
                send_item(CMD_IDLE, byte_t'($urandom), sda_level(sda_mode));
        end
    endtask

    // Command item followed by enough ticks to finish it, sometimes cut short
    task automatic run_command(op_t op, byte_t d, int sda_mode, int gap_max,
                               int noise_pct, bit may_cut);
        int wait_ticks;
        send_item(op, d, sda_level(sda_mode));
        wait_ticks = slots_in(op) * slot_len - 1 + $urandom_range(gap_max);
        if (may_cut && $urandom_range(9) == 0)
            wait_ticks = $urandom_range(wait_ticks);
        tick_run(wait_ticks, sda_mode, noise_pct);
    endtask

    // Wait until every tick item offered so far has its pin item back
    task automatic drain_pins();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pins_due != 0)
            @(posedge clk);
    endtask

    // Tick until the sequencer reports no command running
    task automatic settle_bus();
        drain_pins();
        while (bus_busy)
        begin
            send_item(CMD_IDLE, byte_t'($urandom), 1'($urandom_range(1)));
            drain_pins();
        end
    endtask

    task automatic write_delay(delay_t v);
        settle_bus();
        repeat (2) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        slot_len = (v == 16'd0) ? 1 : int'(v);
    endtask

    // Start, one to three bytes either way, stop
    task automatic run_transfer();
        int n;
        n = $urandom_range(1, 3);
        run_command(CMD_START, byte_t'($urandom), SDA_RAND, 2, 4, 1'b1);
        repeat (n)
        begin
            if ($urandom_range(1))
                run_command(CMD_WRITE, byte_t'($urandom), SDA_RAND, 3, 4, 1'b1);
            else
                run_command(CMD_READ, byte_t'($urandom), SDA_RAND, 3, 4, 1'b1);
        end
        run_command(CMD_STOP, byte_t'($urandom), SDA_RAND, 3, 4, 1'b1);
    endtask

    task automatic random_phase(int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
                run_transfer();
            else
                repeat ($urandom_range(1, 6))
                    send_item(op_t'($urandom_range(0, 7)), byte_t'($urandom),
                              1'($urandom_range(1)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n             <= 1'b0;
        tick_ch.valid     <= 1'b0;
        tick_ch.op        <= CMD_IDLE;
        tick_ch.data_byte <= '0;
        tick_ch.sda_in    <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= DELAY_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unused codes, a full transfer at reset delay, a command
        // while busy, both ack levels, all-ones and all-zeros bytes
        send_item(CMD_IDLE, 8'h00, 1'b0);
        send_item(OP_RSVD_A, 8'hFF, 1'b1);
        send_item(OP_RSVD_B, 8'h5A, 1'b0);
        send_item(OP_RSVD_C, 8'hA5, 1'b1);
        run_command(CMD_START, 8'h00, SDA_RAND, 0, 0, 1'b0);
        send_item(CMD_WRITE, 8'hFF, 1'b0);
        send_item(CMD_READ, 8'h00, 1'b0);
        send_item(OP_RSVD_C, 8'h00, 1'b0);
        tick_run(slots_in(CMD_WRITE) - 3, SDA_ZERO, 0);
        run_command(CMD_WRITE, 8'h00, SDA_ONE, 0, 0, 1'b0);
        run_command(CMD_READ, 8'hFF, SDA_ONE, 0, 0, 1'b0);
        run_command(CMD_READ, 8'h00, SDA_ZERO, 0, 0, 1'b0);
        run_command(CMD_STOP, 8'hFF, SDA_RAND, 1, 0, 1'b0);

        // Sender light idling, receiver heavy, with one long hold-off
        write_delay(16'd1);
        hold_req = hold_req + 1;
        random_phase(90);

        // Roles swapped, zero delay counts as one tick
        tx_idle_pct = 70;
        rx_idle_pct = 14;
        write_delay(16'd0);
        random_phase(90);

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_delay(16'd2);
        random_phase(40);
        write_delay(16'd3);
        random_phase(10);

        // Longest slot: a read stays in its first slot with the counter far below its limit
        write_delay(16'hFFFF);
        send_item(CMD_READ, byte_t'($urandom), 1'($urandom_range(1)));
        tick_run(40, SDA_RAND, 1);

        drain_pins();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pins_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : i2c_master_bit_sequencer_core_test

[i2c_master_bit_sequencer_core.f]
sv/i2cms_pkg.sv
sv/i2cms_if.sv
sv/i2c_master_bit_sequencer_core.sv
test/i2c_master_bit_sequencer_checker.sv
test/i2c_master_bit_sequencer_core_test.sv
